// File: sv/nearest_sample_rate_converter_core_defines.svh
// Assertion macros shared by the resampler checker.
`ifndef NEAREST_SAMPLE_RATE_CONVERTER_CORE_DEFINES_SVH
`define NEAREST_SAMPLE_RATE_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define NSRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define NSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define NSRC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/nsrc_pkg.sv
// Shared types and constants of the nearest-neighbor resampler.
`default_nettype none

package nsrc_pkg;

    // Default sizes
    localparam int STORE_DEPTH_DEF  = 4096;
    localparam int MAX_CHANNELS_DEF = 8;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int LOAD_ADDR_W = 12;
    localparam int CH_W        = 4;
    localparam int CHIDX_W     = 3;
    localparam int STEP_W      = 16;
    localparam int COUNT_W     = 13;
    localparam int OUTCNT_W    = 20;
    localparam int PHASE_W     = 40;
    localparam int FRAC_W      = 8;
    localparam int IDX_W       = 14;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 20;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RATIO    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_COUNT  = 4'd3;

    // Register reset values
    localparam logic [CH_W-1:0]     CH_RESET     = 4'd1;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 16'd256;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 13'd4096;
    localparam logic [OUTCNT_W-1:0] OUTCNT_RESET = 20'd0;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                  opcode;
        logic [LOAD_ADDR_W-1:0]   load_address;
        logic signed [SAMPLE_W-1:0] load_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       final_flag;
        logic                       exhausted;
    } t_out_item;

    // Request to the source index generator
    typedef struct packed {
        logic [COUNT_W-1:0] whole;   // integer phase, valid when over is low
        logic               over;    // integer phase at or past the bound
        logic [CHIDX_W-1:0] chan;    // channel index, below chans
        logic [CH_W-1:0]    chans;   // effective channel count, 1..8
        logic [COUNT_W-1:0] bound;   // clamp bound
    } t_idx_req;

endpackage

`default_nettype wire

// File: sv/nsrc_store.sv
// Sample store: single-port write, registered read.
`default_nettype none

module nsrc_store #(
    parameter int DEPTH = nsrc_pkg::STORE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic [nsrc_pkg::SAMPLE_W-1:0] i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [AW-1:0]                 i_rd_addr,
    output logic      [nsrc_pkg::SAMPLE_W-1:0] o_rd_data
);

    logic [nsrc_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [nsrc_pkg::SAMPLE_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/nsrc_idx_gen.sv
// Source index generator: round phase up to a frame, add channel, clamp.
`default_nettype none

module nsrc_idx_gen (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire nsrc_pkg::t_idx_req         i_req,
    output logic                            o_done,
    output logic [nsrc_pkg::IDX_W-1:0]      o_idx
);

    localparam int PW    = nsrc_pkg::COUNT_W + nsrc_pkg::CH_W;
    localparam int RCP_W = 17;
    localparam int RCP_S = 16;
    localparam int QP_W  = nsrc_pkg::COUNT_W + RCP_W;

    nsrc_pkg::t_idx_req              r_req;
    logic                            r_a_vld;
    logic                            r_b_vld;
    logic                            r_c_vld;
    logic [nsrc_pkg::COUNT_W-1:0]    r_q;
    logic                            r_zero;
    logic [nsrc_pkg::IDX_W-1:0]      r_idx;

    logic [nsrc_pkg::COUNT_W-1:0]    n_q;
    logic [nsrc_pkg::COUNT_W-1:0]    wm1;
    logic [RCP_W-1:0]                recip;
    logic [QP_W-1:0]                 qprod;
    logic [PW-1:0]                   prod;
    logic [nsrc_pkg::IDX_W-1:0]      base;
    logic [nsrc_pkg::IDX_W-1:0]      n_idx;
    logic [nsrc_pkg::IDX_W-1:0]      bound_x;
    logic [nsrc_pkg::IDX_W-1:0]      chans_x;
    logic [nsrc_pkg::IDX_W-1:0]      chan_x;

    // Frame number of the previous sample: (whole - 1) / chans,
    // by reciprocal multiply, exact for every 13-bit dividend
    always_comb begin
        wm1 = r_req.whole - 1'b1;
        unique case (r_req.chans)
            4'd2:    recip = 17'd32768;
            4'd3:    recip = 17'd21846;
            4'd4:    recip = 17'd16384;
            4'd5:    recip = 17'd13108;
            4'd6:    recip = 17'd10923;
            4'd7:    recip = 17'd9363;
            4'd8:    recip = 17'd8192;
            default: recip = 17'd65536;
        endcase
        qprod = QP_W'(wm1) * QP_W'(recip);
        n_q   = qprod[RCP_S +: nsrc_pkg::COUNT_W];
    end

    // Rounded base plus channel, then clamp to the last frame below the bound
    always_comb begin
        prod    = (PW'(r_q) + PW'(1)) * PW'(r_req.chans);
        base    = r_zero ? '0 : prod[nsrc_pkg::IDX_W-1:0];
        bound_x = nsrc_pkg::IDX_W'(r_req.bound);
        chans_x = nsrc_pkg::IDX_W'(r_req.chans);
        chan_x  = nsrc_pkg::IDX_W'(r_req.chan);
        n_idx   = base + chan_x;
        if (r_req.over || (n_idx >= bound_x)) begin
            n_idx = (bound_x >= chans_x) ? (bound_x - chans_x + chan_x) : chan_x;
        end
    end

    // Three register stages: request, quotient, index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_start;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req <= i_req;
        end
        if (r_a_vld) begin
            r_q    <= n_q;
            r_zero <= (r_req.whole == '0);
        end
        if (r_b_vld) begin
            r_idx <= n_idx;
        end
    end

    assign o_done = r_c_vld;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

// File: sv/nearest_sample_rate_converter_core.sv
// Nearest-neighbor resampler for interleaved 16-bit audio: top level.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_data): a transfer
// takes place when valid is high and stall is low. A load writes one sample
// into the store. An emit produces one result on the
// output channel (o_out_valid / i_out_stall, payload o_out_data).
// An emit that finds the run complete gives a zero sample with exhausted set.
// A normal emit passes the request, quotient and index stages of the index
// generator, the store read, a wait state and the output load; an emit that
// finds the run complete goes straight to the output load. The input stalls
// while an emit is in flight, so a new emit is taken only after the last one
// has loaded its result; loads run at one per cycle while none is in flight.
// The output register holds its result while i_out_stall is high; loads are
// still taken then if no emit is in flight, and an emit waits in its last
// step until the slot frees. Configuration writes (i_cfg_valid / o_cfg_ready)
// are to be made only while the block is idle; the block itself does not
// enforce this. Reset clears phase, output counter and channel index and
// restores register defaults; the store is not cleared.
`default_nettype none

module nearest_sample_rate_converter_core #(
    parameter int STORE_DEPTH  = nsrc_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHANNELS = nsrc_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire nsrc_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output nsrc_pkg::t_out_item                    o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [nsrc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [nsrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_READ,
        S_OUT
    } t_state;

    // Configuration registers
    logic [nsrc_pkg::CH_W-1:0]      r_ch_cnt;
    logic [nsrc_pkg::STEP_W-1:0]    r_step;
    logic [nsrc_pkg::COUNT_W-1:0]   r_scount;
    logic [nsrc_pkg::OUTCNT_W-1:0]  r_ocount;

    // Run state
    logic [nsrc_pkg::PHASE_W-1:0]   r_phase;
    logic [nsrc_pkg::OUTCNT_W-1:0]  r_ocnt;
    logic [nsrc_pkg::CHIDX_W-1:0]   r_chan;
    t_state                         r_state;
    logic                           r_pend_final;
    logic                           r_pend_exh;
    logic                           r_out_valid;
    nsrc_pkg::t_out_item            r_out;

    logic [nsrc_pkg::CH_W-1:0]      eff_ch;
    logic [nsrc_pkg::CHIDX_W-1:0]   chan_eff;
    logic [nsrc_pkg::CH_W-1:0]      chan_inc;
    logic [nsrc_pkg::CHIDX_W-1:0]   n_chan;
    logic [nsrc_pkg::PHASE_W-1:0]   n_phase;
    logic [nsrc_pkg::OUTCNT_W-1:0]  n_ocnt;
    logic [nsrc_pkg::COUNT_W-1:0]   bound;
    logic [31:0]                    whole;
    logic                           in_xfer;
    logic                           emit;
    logic                           load;
    logic                           exh;
    logic                           start;
    logic                           out_free;
    logic                           is_final;
    nsrc_pkg::t_idx_req             req;
    logic                           idx_done;
    logic [nsrc_pkg::IDX_W-1:0]     idx;
    logic [31:0]                    rd_addr_x;
    logic [31:0]                    wr_addr_x;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  wr_addr;
    logic                           rd_en;
    logic [nsrc_pkg::SAMPLE_W-1:0]  rd_data;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign emit        = in_xfer && (i_in_data.opcode == nsrc_pkg::OP_EMIT);
    assign load        = in_xfer && (i_in_data.opcode == nsrc_pkg::OP_LOAD);
    assign out_free    = !r_out_valid || !i_out_stall;

    // Effective channel count and channel index
    always_comb begin
        eff_ch = r_ch_cnt;
        if (eff_ch == '0) begin
            eff_ch = nsrc_pkg::CH_W'(1);
        end
        if (eff_ch > nsrc_pkg::CH_W'(MAX_CHANNELS)) begin
            eff_ch = nsrc_pkg::CH_W'(MAX_CHANNELS);
        end
        chan_eff = (nsrc_pkg::CH_W'(r_chan) >= eff_ch) ? '0 : r_chan;
        chan_inc = nsrc_pkg::CH_W'(chan_eff) + nsrc_pkg::CH_W'(1);
        n_chan   = (chan_inc >= eff_ch) ? '0 : chan_inc[nsrc_pkg::CHIDX_W-1:0];
    end

    // Clamp bound and index request
    always_comb begin
        bound = r_scount;
        if (32'(r_scount) > 32'(STORE_DEPTH)) begin
            bound = nsrc_pkg::COUNT_W'(STORE_DEPTH);
        end
        whole     = r_phase[nsrc_pkg::PHASE_W-1:nsrc_pkg::FRAC_W];
        req.whole = whole[nsrc_pkg::COUNT_W-1:0];
        req.over  = (whole >= 32'(bound));
        req.chan  = chan_eff;
        req.chans = eff_ch;
        req.bound = bound;
    end

    assign exh      = (r_ocnt >= r_ocount);
    assign start    = emit && !exh;
    assign is_final = ((21'(r_ocnt) + 21'd1) == 21'(r_ocount));
    assign n_phase  = r_phase + nsrc_pkg::PHASE_W'(r_step);
    assign n_ocnt   = r_ocnt + nsrc_pkg::OUTCNT_W'(1);

    // Store addressing
    assign wr_addr_x = 32'(i_in_data.load_address) % 32'(STORE_DEPTH);
    assign wr_addr   = wr_addr_x[AW-1:0];
    assign rd_addr_x = 32'(idx);
    assign rd_addr   = rd_addr_x[AW-1:0];
    assign rd_en     = (r_state == S_CALC) && idx_done;

    nsrc_idx_gen u_idx_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .o_done  (idx_done),
        .o_idx   (idx)
    );

    nsrc_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (load),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.load_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_cnt <= nsrc_pkg::CH_RESET;
            r_step   <= nsrc_pkg::STEP_RESET;
            r_scount <= nsrc_pkg::COUNT_RESET;
            r_ocount <= nsrc_pkg::OUTCNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                nsrc_pkg::CFG_CHANNEL_COUNT: r_ch_cnt <= i_cfg_data[nsrc_pkg::CH_W-1:0];
                nsrc_pkg::CFG_STEP_RATIO:    r_step   <= i_cfg_data[nsrc_pkg::STEP_W-1:0];
                nsrc_pkg::CFG_SAMPLE_COUNT:  r_scount <= i_cfg_data[nsrc_pkg::COUNT_W-1:0];
                nsrc_pkg::CFG_OUTPUT_COUNT:  r_ocount <= i_cfg_data[nsrc_pkg::OUTCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Emit sequencer, run state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= '0;
            r_ocnt       <= '0;
            r_chan       <= '0;
            r_pend_final <= 1'b0;
            r_pend_exh   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out        <= '0;
        end else begin
            // a taken result clears unless a new one loads in its place
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (emit) begin
                        r_pend_exh   <= exh;
                        r_pend_final <= is_final;
                        r_state      <= exh ? S_OUT : S_CALC;
                        if (!exh) begin
                            r_phase <= n_phase;
                            r_ocnt  <= n_ocnt;
                            r_chan  <= n_chan;
                        end
                    end
                end
                S_CALC: begin
                    if (idx_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.out_sample     <= r_pend_exh ? '0 : rd_data;
                        r_out.final_flag     <= r_pend_exh ? 1'b0 : r_pend_final;
                        r_out.exhausted      <= r_pend_exh;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: sv/nsrc_checker.sv
// Port-level checker for the resampler, bound to the top level.
`default_nettype none
`include "nearest_sample_rate_converter_core_defines.svh"

module nsrc_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_stall,
    input  wire nsrc_pkg::t_in_item                i_in_data,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire nsrc_pkg::t_out_item               o_out_data,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              o_cfg_ready,
    input  wire logic [nsrc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [nsrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic emit_xfer;

    assign emit_xfer = i_in_valid && !o_in_stall &&
                       (i_in_data.opcode == nsrc_pkg::OP_EMIT);

    // A stalled result stays put
    `NSRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "output result changed under stall")

    // Exhausted results carry a zero sample and no final flag
    `NSRC_ASSERT_NOW(a_exh_zero, i_clk, i_rst_n, o_out_valid && o_out_data.exhausted, (o_out_data.out_sample == '0) && !o_out_data.final_flag, "exhausted result not zero")

    // An emit transfer blocks the input on the next cycle
    `NSRC_ASSERT_NEXT(a_emit_blocks, i_clk, i_rst_n, emit_xfer, o_in_stall, "input open while emit in flight")

    // Reset leaves the block idle with no result
    `NSRC_ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "block not idle after reset")

    // Configuration port never back-pressures and carries known values
    `NSRC_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready && !$isunknown({i_cfg_index, i_cfg_data}), "config write refused or unknown")

endmodule

bind nearest_sample_rate_converter_core nsrc_checker u_nsrc_checker (.*);

`default_nettype wire
